// ----- rtl/m3i_pkg.sv -----
// Shared types and fixed widths for the 3x3 matrix inverse / adjugate pipeline.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package m3i_pkg;

    localparam int DATA_W  = 32;
    localparam int MINOR_W = 2 * DATA_W + 1;
    localparam int DET_W   = 3 * DATA_W + 1;
    localparam int LANES   = 9;

    typedef logic signed [DATA_W-1:0]  t_word;
    typedef logic signed [MINOR_W-1:0] t_minor;
    typedef logic signed [DET_W-1:0]   t_det;

    typedef enum logic {
        ACT_INVERSE  = 1'b0,
        ACT_ADJUGATE = 1'b1
    } t_action;

    typedef struct packed {
        logic  action;
        t_word in_r0c0;
        t_word in_r0c1;
        t_word in_r0c2;
        t_word in_r1c0;
        t_word in_r1c1;
        t_word in_r1c2;
        t_word in_r2c0;
        t_word in_r2c1;
        t_word in_r2c2;
    } t_req;

    typedef struct packed {
        t_word out_r0c0;
        t_word out_r0c1;
        t_word out_r0c2;
        t_word out_r1c0;
        t_word out_r1c1;
        t_word out_r1c2;
        t_word out_r2c0;
        t_word out_r2c1;
        t_word out_r2c2;
        t_word det_value;
        logic  singular;
    } t_rsp;

    // Adjugate entries (row-major) plus what the determinant stages still need.
    typedef struct packed {
        logic                action;
        t_word  [2:0]        row0;
        t_minor [LANES-1:0]  adj;
    } t_cof;

    // Sideband carried alongside the divider lanes.
    typedef struct packed {
        logic               adj_mode;
        logic               singular;
        t_word              det_value;
        t_word [LANES-1:0]  adj_out;
    } t_side;

endpackage

// ----- rtl/m3i_cof.sv -----
// Cofactor stages: eighteen 2x2 products, then the signed minors (adjugate entries).
// Depends on m3i_pkg.
module m3i_cof (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  m3i_pkg::t_req  i_req,
    output logic           o_valid,
    output m3i_pkg::t_cof  o_cof
);

    localparam int DATA_W  = m3i_pkg::DATA_W;
    localparam int MINOR_W = m3i_pkg::MINOR_W;
    localparam int LANES   = m3i_pkg::LANES;
    localparam int P_W     = 2 * DATA_W;
    localparam int KEEP_A [3] = '{1, 0, 0};
    localparam int KEEP_B [3] = '{2, 2, 1};

    m3i_pkg::t_word           a [3][3];
    logic signed [P_W-1:0]    n_pa [LANES];
    logic signed [P_W-1:0]    n_pb [LANES];
    logic signed [P_W-1:0]    r_pa [LANES];
    logic signed [P_W-1:0]    r_pb [LANES];
    logic                     r_act1;
    m3i_pkg::t_word [2:0]     r_row0;
    logic                     r_vld1;
    logic                     r_vld2;
    m3i_pkg::t_cof            n_cof;
    m3i_pkg::t_cof            r_cof;

    always_comb begin
        a[0][0] = i_req.in_r0c0;
        a[0][1] = i_req.in_r0c1;
        a[0][2] = i_req.in_r0c2;
        a[1][0] = i_req.in_r1c0;
        a[1][1] = i_req.in_r1c1;
        a[1][2] = i_req.in_r1c2;
        a[2][0] = i_req.in_r2c0;
        a[2][1] = i_req.in_r2c1;
        a[2][2] = i_req.in_r2c2;
    end

    // adj[r][c] is the minor that leaves out row c and column r
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_pa[3*r+c] = a[KEEP_A[c]][KEEP_A[r]] * a[KEEP_B[c]][KEEP_B[r]];
                n_pb[3*r+c] = a[KEEP_B[c]][KEEP_A[r]] * a[KEEP_A[c]][KEEP_B[r]];
            end
        end
    end

    always_comb begin
        m3i_pkg::t_minor mn;
        n_cof.action = r_act1;
        n_cof.row0   = r_row0;
        for (int k = 0; k < LANES; k++) begin
            mn = MINOR_W'(r_pa[k]) - MINOR_W'(r_pb[k]);
            n_cof.adj[k] = ((k % 2) == 1) ? -mn : mn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa      <= n_pa;
            r_pb      <= n_pb;
            r_act1    <= i_req.action;
            r_row0[0] <= i_req.in_r0c0;
            r_row0[1] <= i_req.in_r0c1;
            r_row0[2] <= i_req.in_r0c2;
            r_cof     <= n_cof;
        end
    end

    assign o_valid = r_vld2;
    assign o_cof   = r_cof;

endmodule

// ----- rtl/m3i_det.sv -----
// Determinant stages: top-row cofactor expansion with split partial products.
// Depends on m3i_pkg.
module m3i_det (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  m3i_pkg::t_cof  i_cof,
    output logic           o_valid,
    output m3i_pkg::t_det  o_det,
    output m3i_pkg::t_cof  o_cof
);

    localparam int DATA_W  = m3i_pkg::DATA_W;
    localparam int MINOR_W = m3i_pkg::MINOR_W;
    localparam int DET_W   = m3i_pkg::DET_W;
    localparam int LO_W    = MINOR_W - DATA_W;
    localparam int HI_P_W  = 2 * DATA_W;
    localparam int LO_P_W  = DATA_W + LO_W + 1;

    logic signed [HI_P_W-1:0] n_phi [3];
    logic signed [LO_P_W-1:0] n_plo [3];
    logic signed [HI_P_W-1:0] r_phi [3];
    logic signed [LO_P_W-1:0] r_plo [3];
    m3i_pkg::t_det            n_prod [3];
    m3i_pkg::t_det            r_prod [3];
    m3i_pkg::t_det            r_det;
    m3i_pkg::t_cof            r_cof3;
    m3i_pkg::t_cof            r_cof4;
    m3i_pkg::t_cof            r_cof5;
    logic                     r_vld3;
    logic                     r_vld4;
    logic                     r_vld5;

    // split the three top-row cofactors (adjugate column 0) into a signed high word and an unsigned low part
    always_comb begin
        m3i_pkg::t_minor        adj_j;
        logic [LO_W-1:0]        lo;
        logic [DATA_W-1:0]      hi;
        for (int j = 0; j < 3; j++) begin
            adj_j    = $signed(i_cof.adj[3*j]);
            hi       = adj_j[MINOR_W-1:LO_W];
            lo       = adj_j[LO_W-1:0];
            n_phi[j] = $signed(i_cof.row0[j]) * $signed(hi);
            n_plo[j] = $signed(i_cof.row0[j]) * $signed({1'b0, lo});
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_prod[j] = (DET_W'(r_phi[j]) <<< LO_W) + DET_W'(r_plo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else if (i_en) begin
            r_vld3 <= i_valid;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phi  <= n_phi;
            r_plo  <= n_plo;
            r_cof3 <= i_cof;
            r_prod <= n_prod;
            r_cof4 <= r_cof3;
            r_det  <= r_prod[0] + r_prod[1] + r_prod[2];
            r_cof5 <= r_cof4;
        end
    end

    assign o_valid = r_vld5;
    assign o_det   = r_det;
    assign o_cof   = r_cof5;

endmodule

// ----- rtl/m3i_div.sv -----
// Nine-lane restoring divider, one quotient bit per stage, shared divisor per stage.
// Depends on m3i_pkg.
module m3i_div #(
    parameter int TOP_W = 98
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic                                         i_valid,
    input  logic [m3i_pkg::LANES-1:0][TOP_W-1:0]         i_top,
    input  logic [m3i_pkg::LANES-1:0]                    i_neg,
    input  logic [m3i_pkg::DET_W-1:0]                    i_d2,
    input  m3i_pkg::t_side                               i_side,
    output logic                                         o_valid,
    output logic [m3i_pkg::LANES-1:0][m3i_pkg::DATA_W-1:0] o_quo,
    output logic [m3i_pkg::LANES-1:0]                    o_ovf,
    output logic [m3i_pkg::LANES-1:0]                    o_neg,
    output m3i_pkg::t_side                               o_side
);

    localparam int DATA_W = m3i_pkg::DATA_W;
    localparam int DET_W  = m3i_pkg::DET_W;
    localparam int LANES  = m3i_pkg::LANES;

    logic                 r_vld  [DATA_W+1];
    m3i_pkg::t_side       r_side [DATA_W+1];
    logic [DET_W-1:0]     r_d2   [DATA_W+1];
    logic [DET_W-1:0]     r_rem  [DATA_W+1][LANES];
    logic [DATA_W-1:0]    r_low  [DATA_W+1][LANES];
    logic [DATA_W-1:0]    r_quo  [DATA_W+1][LANES];
    logic                 r_ovf  [DATA_W+1][LANES];
    logic                 r_neg  [DATA_W+1][LANES];

    // entry stage: flag quotients of 2^DATA_W or more, seed the remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_d2[0]   <= i_d2;
            for (int l = 0; l < LANES; l++) begin
                r_ovf[0][l] <= DET_W'(i_top[l][TOP_W-1:DATA_W]) >= i_d2;
                r_rem[0][l] <= DET_W'(i_top[l][TOP_W-1:DATA_W]);
                r_low[0][l] <= i_top[l][DATA_W-1:0];
                r_quo[0][l] <= '0;
                r_neg[0][l] <= i_neg[l];
            end
        end
    end

    for (genvar k = 1; k <= DATA_W; k++) begin : g_step
        logic [DET_W:0] trial [LANES];
        logic           take  [LANES];

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = {r_rem[k-1][l], r_low[k-1][l][DATA_W-1]};
                take[l]  = trial[l] >= {1'b0, r_d2[k-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= r_side[k-1];
                r_d2[k]   <= r_d2[k-1];
                for (int l = 0; l < LANES; l++) begin
                    r_rem[k][l] <= take[l] ? DET_W'(trial[l] - {1'b0, r_d2[k-1]})
                                           : DET_W'(trial[l]);
                    r_low[k][l] <= {r_low[k-1][l][DATA_W-2:0], 1'b0};
                    r_quo[k][l] <= {r_quo[k-1][l][DATA_W-2:0], take[l]};
                    r_ovf[k][l] <= r_ovf[k-1][l];
                    r_neg[k][l] <= r_neg[k-1][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_quo[DATA_W][l];
            o_ovf[l] = r_ovf[DATA_W][l];
            o_neg[l] = r_neg[DATA_W][l];
        end
    end

    assign o_valid = r_vld[DATA_W];
    assign o_side  = r_side[DATA_W];

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DATA_W] && !r_ovf[DATA_W][0] |-> r_rem[DATA_W][0] < r_d2[DATA_W])
        else $error("divider remainder not below divisor");

endmodule

// ----- rtl/matrix3_inverse_adjugate.sv -----
// Pipeline: DATA_W + 8 register stages (40 at Q16.16), most of them in the
// one-bit-per-stage divider that forms the inverse.
// Throughput: one request per cycle while the output is taken or empty; a held output
// freezes every stage, so nothing is lost or repeated.
// Reset (synchronous, active low) clears every stage valid bit; data registers
// keep whatever they hold.
module matrix3_inverse_adjugate #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  m3i_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output m3i_pkg::t_rsp  o_rsp
);

    localparam int DATA_W  = m3i_pkg::DATA_W;
    localparam int MINOR_W = m3i_pkg::MINOR_W;
    localparam int DET_W   = m3i_pkg::DET_W;
    localparam int LANES   = m3i_pkg::LANES;
    // dividend 2|adj| * 2^(2F) + |det|
    localparam int TOP_W   = (((2 * DATA_W + 2 * FRAC_BITS + 1) > 3 * DATA_W)
                              ? (2 * DATA_W + 2 * FRAC_BITS + 1) : 3 * DATA_W) + 1;
    localparam logic [DET_W:0]  ONE_WIDE  = (DET_W+1)'(1);
    localparam logic [DET_W:0]  HALF_A    = (ONE_WIDE << FRAC_BITS) >> 1;
    localparam logic [DET_W:0]  HALF_D    = (ONE_WIDE << (2 * FRAC_BITS)) >> 1;
    localparam logic [DATA_W-1:0] MIN_WORD = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MAX_WORD = {1'b0, {(DATA_W-1){1'b1}}};

    // Round to nearest (ties away from zero) after a right shift, then clamp.
    function automatic m3i_pkg::t_word round_sat(input m3i_pkg::t_det v,
                                                  input logic [DET_W:0] half,
                                                  input int sh);
        logic             neg;
        logic [DET_W-1:0] mag;
        logic [DET_W:0]   scaled;
        logic [DET_W:0]   lim;
        neg    = v[DET_W-1];
        mag    = neg ? DET_W'(-v) : DET_W'(v);
        scaled = ({1'b0, mag} + half) >> sh;
        lim    = (DET_W+1)'(MIN_WORD);
        if (neg) begin
            return (scaled > lim) ? m3i_pkg::t_word'(MIN_WORD)
                                  : m3i_pkg::t_word'(-scaled[DATA_W-1:0]);
        end
        return (scaled >= lim) ? m3i_pkg::t_word'(MAX_WORD)
                               : m3i_pkg::t_word'(scaled[DATA_W-1:0]);
    endfunction

    // Global advance: the whole pipe moves unless a finished result is held.
    logic                                   adv;
    logic                                   cof_vld;
    m3i_pkg::t_cof                          cof_data;
    logic                                   det_vld;
    m3i_pkg::t_det                          det_data;
    m3i_pkg::t_cof                          det_cof;

    // Prep stage: magnitudes, signs, dividends, and the adjugate-mode answers.
    logic [LANES-1:0][TOP_W-1:0]            n_top;
    logic [LANES-1:0]                       n_neg;
    logic [DET_W-1:0]                       n_d2;
    m3i_pkg::t_side                         n_side;
    logic [LANES-1:0][TOP_W-1:0]            r_top;
    logic [LANES-1:0]                       r_neg;
    logic [DET_W-1:0]                       r_d2;
    m3i_pkg::t_side                         r_side;
    logic                                   r_pv;

    logic                                   div_vld;
    logic [LANES-1:0][DATA_W-1:0]           div_quo;
    logic [LANES-1:0]                       div_ovf;
    logic [LANES-1:0]                       div_neg;
    m3i_pkg::t_side                         div_side;

    m3i_pkg::t_word                         res [LANES];
    m3i_pkg::t_rsp                          n_rsp;
    m3i_pkg::t_rsp                          r_rsp;
    logic                                   r_out_vld;

    assign adv     = !r_out_vld || i_ready;
    assign o_ready = adv;

    m3i_cof u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_valid (cof_vld),
        .o_cof   (cof_data)
    );

    m3i_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (cof_vld),
        .i_cof   (cof_data),
        .o_valid (det_vld),
        .o_det   (det_data),
        .o_cof   (det_cof)
    );

    always_comb begin
        logic [DET_W-1:0]    d_mag;
        m3i_pkg::t_minor     adj_l;
        logic [MINOR_W-1:0]  a_mag;
        d_mag           = det_data[DET_W-1] ? DET_W'(-det_data) : DET_W'(det_data);
        // |det| stays below 2^(DET_W-1), so doubling it fits
        n_d2            = {d_mag[DET_W-2:0], 1'b0};
        n_side.adj_mode = det_cof.action == m3i_pkg::ACT_ADJUGATE;
        n_side.singular = det_data == '0;
        n_side.det_value = round_sat(det_data, HALF_D, 2 * FRAC_BITS);
        for (int l = 0; l < LANES; l++) begin
            adj_l    = $signed(det_cof.adj[l]);
            a_mag    = adj_l[MINOR_W-1] ? MINOR_W'(-adj_l) : MINOR_W'(adj_l);
            n_top[l] = (TOP_W'({a_mag, 1'b0}) << (2 * FRAC_BITS)) + TOP_W'(d_mag);
            n_neg[l] = adj_l[MINOR_W-1] ^ det_data[DET_W-1];
            n_side.adj_out[l] = round_sat(DET_W'(adj_l), HALF_A, FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (adv) begin
            r_pv <= det_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_top  <= n_top;
            r_neg  <= n_neg;
            r_d2   <= n_d2;
            r_side <= n_side;
        end
    end

    m3i_div #(
        .TOP_W (TOP_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_pv),
        .i_top   (r_top),
        .i_neg   (r_neg),
        .i_d2    (r_d2),
        .i_side  (r_side),
        .o_valid (div_vld),
        .o_quo   (div_quo),
        .o_ovf   (div_ovf),
        .o_neg   (div_neg),
        .o_side  (div_side)
    );

    // Final stage: sign and clamp each quotient, then pick the answer by action (zero for a singular inverse).
    always_comb begin
        m3i_pkg::t_word inv;
        for (int l = 0; l < LANES; l++) begin
            if (div_ovf[l]) begin
                inv = div_neg[l] ? m3i_pkg::t_word'(MIN_WORD) : m3i_pkg::t_word'(MAX_WORD);
            end else if (div_neg[l]) begin
                inv = (div_quo[l] > MIN_WORD) ? m3i_pkg::t_word'(MIN_WORD)
                                              : m3i_pkg::t_word'(-div_quo[l]);
            end else begin
                inv = (div_quo[l] >= MIN_WORD) ? m3i_pkg::t_word'(MAX_WORD)
                                               : m3i_pkg::t_word'(div_quo[l]);
            end
            if (div_side.adj_mode) begin
                res[l] = div_side.adj_out[l];
            end else if (div_side.singular) begin
                res[l] = '0;
            end else begin
                res[l] = inv;
            end
        end
        n_rsp.out_r0c0  = res[0];
        n_rsp.out_r0c1  = res[1];
        n_rsp.out_r0c2  = res[2];
        n_rsp.out_r1c0  = res[3];
        n_rsp.out_r1c1  = res[4];
        n_rsp.out_r1c2  = res[5];
        n_rsp.out_r2c0  = res[6];
        n_rsp.out_r2c1  = res[7];
        n_rsp.out_r2c2  = res[8];
        n_rsp.det_value = div_side.det_value;
        n_rsp.singular  = div_side.singular;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

    a_singular_det_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_rsp.singular |-> r_rsp.det_value == '0)
        else $error("singular result with nonzero determinant");

    a_singular_matches_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_side.singular == (r_d2 == '0)))
        else $error("singular flag disagrees with divisor");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

endmodule

// ----- tb/tb_matrix3_inverse_adjugate.sv -----
// Testbench for matrix3_inverse_adjugate: drives 3x3 Q16.16 matrices through the
// valid/ready request channel and checks every response against an exact predictor.
// Depends on m3i_pkg and the block itself.
`timescale 1ns / 100ps

module tb_matrix3_inverse_adjugate;

    typedef m3i_pkg::t_word   t_word;
    typedef m3i_pkg::t_req    t_req;
    typedef m3i_pkg::t_rsp    t_rsp;
    typedef m3i_pkg::t_action t_action;
    localparam t_action ACT_INVERSE  = m3i_pkg::ACT_INVERSE;
    localparam t_action ACT_ADJUGATE = m3i_pkg::ACT_ADJUGATE;
    localparam int DATA_W = m3i_pkg::DATA_W;

    localparam int FRAC = 16;
    localparam int LAT  = DATA_W + 8;
    // Wide enough for adjugate << 32 and the determinant with headroom.
    localparam int BW   = 200;
    typedef logic signed [BW-1:0] t_big;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_req  i_req = '0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    t_rsp  o_rsp;

    matrix3_inverse_adjugate #(.FRAC_BITS(FRAC)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    always #2 i_clk = ~i_clk;

    t_rsp rsp_pending[$];
    int   err_count = 0;
    int   rsp_count = 0;
    int   sing_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_off = 1'b0;

    // ---------------------------------------------------------------
    // Exact arithmetic helpers: round to nearest, ties away from zero.
    // ---------------------------------------------------------------
    function automatic t_big shr_round(t_big v, int s);
        t_big m;
        m = (v < 0) ? -v : v;
        if (s > 0) m = (m + (t_big'(1) <<< (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic t_big div_round(t_big num, t_big den);
        t_big an, ad, q;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q  = (2 * an + ad) / (2 * ad);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic t_word clamp_word(t_big v);
        t_big hi, lo;
        hi = (t_big'(1) <<< (DATA_W - 1)) - 1;
        lo = -(t_big'(1) <<< (DATA_W - 1));
        if (v > hi) return t_word'(hi);
        if (v < lo) return t_word'(lo);
        return t_word'(v);
    endfunction

    // Predict the whole response for one request.
    function automatic t_rsp inverse_of(t_req rq);
        t_big  m[3][3];
        t_big  adj[3][3];
        t_big  det;
        t_word res[9];
        t_rsp  r;
        int    ra0, ra1, ca0, ca1;
        m[0][0] = rq.in_r0c0; m[0][1] = rq.in_r0c1; m[0][2] = rq.in_r0c2;
        m[1][0] = rq.in_r1c0; m[1][1] = rq.in_r1c1; m[1][2] = rq.in_r1c2;
        m[2][0] = rq.in_r2c0; m[2][1] = rq.in_r2c1; m[2][2] = rq.in_r2c2;
        // adj[i][j] is the signed minor that leaves out row j and column i
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ra0 = (j == 0) ? 1 : 0;
                ra1 = (j == 2) ? 1 : 2;
                ca0 = (i == 0) ? 1 : 0;
                ca1 = (i == 2) ? 1 : 2;
                adj[i][j] = m[ra0][ca0] * m[ra1][ca1] - m[ra1][ca0] * m[ra0][ca1];
                if ((i + j) % 2) adj[i][j] = -adj[i][j];
            end
        end
        det = m[0][0] * adj[0][0] + m[0][1] * adj[1][0] + m[0][2] * adj[2][0];
        for (int k = 0; k < 9; k++) begin
            if (t_action'(rq.action) == ACT_ADJUGATE)
                res[k] = clamp_word(shr_round(adj[k/3][k%3], FRAC));
            else if (det == 0)
                res[k] = '0;
            else
                res[k] = clamp_word(div_round(adj[k/3][k%3] <<< (2 * FRAC), det));
        end
        r.out_r0c0 = res[0]; r.out_r0c1 = res[1]; r.out_r0c2 = res[2];
        r.out_r1c0 = res[3]; r.out_r1c1 = res[4]; r.out_r1c2 = res[5];
        r.out_r2c0 = res[6]; r.out_r2c1 = res[7]; r.out_r2c2 = res[8];
        r.det_value = clamp_word(shr_round(det, 2 * FRAC));
        r.singular  = (det == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, t_word got, t_word want);
        err_count++;
        $display("mismatch on response %0d: %s got %0d want %0d",
                 rsp_count, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Request side: hold valid and payload until accepted; leave valid up
    // afterwards so the next request can follow without a gap.
    // ---------------------------------------------------------------
    task automatic send_req(t_req rq);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= rq;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        rsp_pending.push_back(inverse_of(rq));
    endtask

    task automatic send_done();
        i_valid <= 1'b0;
    endtask

    // Response side: random stall, plus a long hold-off on demand.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sample on the edge: o_valid and i_ready seen together are a handshake.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            rsp_count++;
            if (rsp_pending.size() == 0) begin
                err_count++;
                $display("response %0d arrived with nothing expected", rsp_count);
            end else begin
                want = rsp_pending.pop_front();
                if (want.singular) sing_count++;
                if (o_rsp.out_r0c0 != want.out_r0c0)
                    report_mismatch("out_r0c0", o_rsp.out_r0c0, want.out_r0c0);
                if (o_rsp.out_r0c1 != want.out_r0c1)
                    report_mismatch("out_r0c1", o_rsp.out_r0c1, want.out_r0c1);
                if (o_rsp.out_r0c2 != want.out_r0c2)
                    report_mismatch("out_r0c2", o_rsp.out_r0c2, want.out_r0c2);
                if (o_rsp.out_r1c0 != want.out_r1c0)
                    report_mismatch("out_r1c0", o_rsp.out_r1c0, want.out_r1c0);
                if (o_rsp.out_r1c1 != want.out_r1c1)
                    report_mismatch("out_r1c1", o_rsp.out_r1c1, want.out_r1c1);
                if (o_rsp.out_r1c2 != want.out_r1c2)
                    report_mismatch("out_r1c2", o_rsp.out_r1c2, want.out_r1c2);
                if (o_rsp.out_r2c0 != want.out_r2c0)
                    report_mismatch("out_r2c0", o_rsp.out_r2c0, want.out_r2c0);
                if (o_rsp.out_r2c1 != want.out_r2c1)
                    report_mismatch("out_r2c1", o_rsp.out_r2c1, want.out_r2c1);
                if (o_rsp.out_r2c2 != want.out_r2c2)
                    report_mismatch("out_r2c2", o_rsp.out_r2c2, want.out_r2c2);
                if (o_rsp.det_value != want.det_value)
                    report_mismatch("det_value", o_rsp.det_value, want.det_value);
                if (o_rsp.singular != want.singular)
                    report_mismatch("singular", t_word'(o_rsp.singular),
                                    t_word'(want.singular));
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus shaping
    // ---------------------------------------------------------------
    localparam t_word ONE  = 32'sh0001_0000;
    localparam t_word WMAX = 32'sh7fff_ffff;
    localparam t_word WMIN = 32'sh8000_0000;

    function automatic t_req make_req(t_action act, t_word a, t_word b, t_word c,
                                      t_word d, t_word e, t_word f,
                                      t_word g, t_word h, t_word k);
        t_req rq;
        rq.action = act;
        rq.in_r0c0 = a; rq.in_r0c1 = b; rq.in_r0c2 = c;
        rq.in_r1c0 = d; rq.in_r1c1 = e; rq.in_r1c2 = f;
        rq.in_r2c0 = g; rq.in_r2c1 = h; rq.in_r2c2 = k;
        return rq;
    endfunction

    // Entry drawn from a spread of magnitudes so that both modest results
    // and saturation turn up.
    function automatic t_word rand_entry();
        case ($urandom_range(5))
            0: return $urandom;
            1: return t_word'($signed($urandom_range(8 * 65536)) - 4 * 65536);
            2: return t_word'($signed($urandom_range(512)) - 256);
            3: return t_word'($signed($urandom_range(2000)) - 1000) <<< 16;
            4: return ($urandom_range(1)) ? WMAX : WMIN;
            default: return t_word'($signed($urandom_range(65536)) - 32768) <<< 4;
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req rq;
        rq = make_req(t_action'($urandom_range(1)), rand_entry(), rand_entry(),
                      rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                      rand_entry(), rand_entry(), rand_entry());
        // make a share singular: copy one row onto another, or zero a column
        case ($urandom_range(7))
            0: begin
                rq.in_r2c0 = rq.in_r0c0; rq.in_r2c1 = rq.in_r0c1;
                rq.in_r2c2 = rq.in_r0c2;
            end
            1: begin
                rq.in_r0c1 = '0; rq.in_r1c1 = '0; rq.in_r2c1 = '0;
            end
            default: ;
        endcase
        return rq;
    endfunction

    // Directed table: rows with typed-in answers are compared here as well
    // as by the predictor.
    typedef struct {
        t_req rq;
        bit   typed;
        t_rsp want;
    } t_row;

    t_row dir_rows[$];

    task automatic add_row(t_req rq, bit typed, t_rsp want);
        t_row r;
        r.rq = rq; r.typed = typed; r.want = want;
        dir_rows.push_back(r);
    endtask

    function automatic t_rsp rsp_of(t_word d0, t_word d4, t_word d8, t_word dv, logic s);
        t_rsp r;
        r = '0;
        r.out_r0c0 = d0; r.out_r1c1 = d4; r.out_r2c2 = d8;
        r.det_value = dv; r.singular = s;
        return r;
    endfunction

    task automatic build_directed();
        t_rsp z;
        z = '0;
        // identity: inverse and adjugate are both the identity
        add_row(make_req(ACT_INVERSE, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1,
                rsp_of(ONE, ONE, ONE, ONE, 1'b0));
        add_row(make_req(ACT_ADJUGATE, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1,
                rsp_of(ONE, ONE, ONE, ONE, 1'b0));
        // zero matrix: singular, inverse all zero
        z.singular = 1'b1;
        add_row(make_req(ACT_INVERSE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z);
        add_row(make_req(ACT_ADJUGATE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z);
        // singular with nonzero adjugate
        add_row(make_req(ACT_INVERSE, ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE,
                         4*ONE, 5*ONE, 7*ONE), 1, z);
        add_row(make_req(ACT_ADJUGATE, ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE,
                         4*ONE, 5*ONE, 7*ONE), 0, z);
        // extremes: full-scale diagonal saturates the adjugate and determinant
        add_row(make_req(ACT_ADJUGATE, WMAX, 0, 0, 0, WMAX, 0, 0, 0, WMAX), 1,
                rsp_of(WMAX, WMAX, WMAX, WMAX, 1'b0));
        add_row(make_req(ACT_INVERSE, WMIN, 0, 0, 0, WMIN, 0, 0, 0, WMIN), 0, z);
        add_row(make_req(ACT_ADJUGATE, WMIN, WMIN, WMIN, WMIN, WMAX, WMIN,
                         WMAX, WMIN, WMAX), 0, z);
        add_row(make_req(ACT_INVERSE, WMAX, WMIN, WMAX, WMIN, WMAX, WMAX,
                         WMAX, WMAX, WMIN), 0, z);
        add_row(make_req(ACT_INVERSE, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1, z);
        // tiny determinant: one LSB on the diagonal, det rounds to zero,
        // inverse saturates and singular stays low
        add_row(make_req(ACT_INVERSE, 1, 0, 0, 0, 1, 0, 0, 0, 1), 1,
                rsp_of(WMAX, WMAX, WMAX, 0, 1'b0));
        add_row(make_req(ACT_INVERSE, -1, 0, 0, 0, 1, 0, 0, 0, 1), 1,
                rsp_of(WMIN, WMAX, WMAX, 0, 1'b0));
        // rounding ties: half an LSB after shifting
        add_row(make_req(ACT_ADJUGATE, 32'sh8000, 0, 0, 0, 1, 0, 0, 0, 1), 0, z);
        add_row(make_req(ACT_ADJUGATE, -32'sh8000, 0, 0, 0, 1, 0, 0, 0, 3), 0, z);
        add_row(make_req(ACT_INVERSE, 2*ONE, ONE, 0, ONE, 3*ONE, ONE, 0, ONE, 4*ONE),
                0, z);
        add_row(make_req(ACT_INVERSE, 3*ONE, 0, 0, 0, 3*ONE, 0, 0, 0, 3*ONE), 0, z);
        add_row(make_req(ACT_INVERSE, 0, ONE, 0, 0, 0, ONE, ONE, 0, 0), 0, z);
        add_row(make_req(ACT_ADJUGATE, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f,
                         32'shf0f0_f0f0, 32'sh3333_3333, 32'shcccc_cccc,
                         32'sh0000_ffff, 32'shffff_0000, 32'sh1234_5678), 0, z);
    endtask

    // Wait until every expected response has been seen.
    task automatic drain();
        while (rsp_pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) send_req(rand_req());
        send_done();
        drain();
    endtask

    // Long receiver hold-off, counted in its own process, while requests keep
    // coming so the pipeline fills and o_ready drops.
    initial begin
        wait (i_rst_n);
        wait (rsp_count >= 100);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (3 * LAT) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        t_rsp got_typed;
        build_directed();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; typed answers are checked against the predictor so
        // a slip in either shows up as a failure here
        foreach (dir_rows[i]) begin
            if (dir_rows[i].typed) begin
                got_typed = inverse_of(dir_rows[i].rq);
                if (got_typed.out_r0c0 != dir_rows[i].want.out_r0c0 ||
                    got_typed.out_r1c1 != dir_rows[i].want.out_r1c1 ||
                    got_typed.out_r2c2 != dir_rows[i].want.out_r2c2 ||
                    got_typed.det_value != dir_rows[i].want.det_value ||
                    got_typed.singular != dir_rows[i].want.singular)
                    report_mismatch("table row", t_word'(i), t_word'(i));
            end
            send_req(dir_rows[i].rq);
        end
        send_done();
        drain();

        // back-to-back, then each idling mix
        random_phase(250, 0, 0);
        random_phase(180, 77, 0);
        random_phase(180, 0, 77);
        random_phase(190, 25, 25);
        send_idle_pct = 0;
        recv_stall_pct = 0;

        repeat (LAT + 10) @(posedge i_clk);
        $display("covered %0d responses, %0d singular, over four idling mixes",
                 rsp_count, sing_count);
        $display("including a long output hold-off with the input back-pressured");
        if (err_count == 0 && rsp_pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/m3i_pkg.sv
rtl/m3i_cof.sv
rtl/m3i_det.sv
rtl/m3i_div.sv
rtl/matrix3_inverse_adjugate.sv
tb/tb_matrix3_inverse_adjugate.sv
